// ===== design/mfr_pkg.sv =====
// shared types and constants for the marker frame receiver
package mfr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_START      = 3'd1,
    EV_RESTART    = 3'd2,
    EV_STORED     = 3'd3,
    EV_COMPLETE   = 3'd4,
    EV_OVERFLOW   = 3'd5,
    EV_TO_DROP    = 3'd6,
    EV_TO_DELIVER = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    REG_SOF_BYTE      = 2'd0,
    REG_EOF_BYTE      = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } reg_idx_e;

  localparam int unsigned PaddrWidth = 4;
  localparam int unsigned PdataWidth = 32;
  localparam int unsigned LenWidth   = 9;
  localparam int unsigned IdxWidth   = 9;

  localparam logic [7:0]  SofByteRst      = 8'd60;
  localparam logic [7:0]  EofByteRst      = 8'd62;
  localparam logic [15:0] TimeoutTicksRst = 16'd2000;
  localparam logic [15:0] TicksMax        = 16'hFFFF;
  localparam logic [7:0]  BraceClose      = 8'h7D;
  localparam int unsigned PrefixLen       = 6;
  localparam int unsigned MinDeliverLen   = 10;

  typedef struct packed {
    logic [7:0]  sof_byte;
    logic [7:0]  eof_byte;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    event_e                ev;
    logic [LenWidth-1:0]   frame_length;
    logic                  frame_open;
    logic                  rd_sel;
  } result_t;

  function automatic logic [7:0] prefix_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h44;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h41;
      3'd4:    b = 8'h3A;
      3'd5:    b = 8'h7B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/mfr_if.sv =====
// stream interfaces for input and result words
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic [8:0] read_index;

  modport source (output valid, output operation, output rx_byte, output read_index,
                  input ready);
  modport sink (input valid, input operation, input rx_byte, input read_index,
                output ready);
endinterface

interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [8:0] frame_length;
  logic [7:0] read_byte;
  logic       frame_open;

  modport source (output valid, output event_res, output frame_length, output read_byte,
                  output frame_open, input ready);
  modport sink (input valid, input event_res, input frame_length, input read_byte,
                input frame_open, output ready);
endinterface

// ===== design/marker_frame_receiver_core.sv =====
// top level of the marker frame receiver
//
//  channel    dir  handshake        payload
//  items_i    in   valid/ready      operation, rx_byte, read_index
//  results_o  out  valid/ready      event_res, frame_length, read_byte, frame_open
//  apb        in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
//  one word in per cycle while the output is not stalled; each result passes
//  through stage one, the buffer read/write cycle, then stage two, the output register
//  input stays ready while the output register alone holds a waiting result
//  reset clears frame state and loads the marker and timeout defaults
//  buffer contents are not cleared by reset
module marker_frame_receiver_core #(
  parameter int unsigned BUFFER_DEPTH = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mfr_in_if.sink                          items_i,
  mfr_out_if.source                       results_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mfr_pkg::PaddrWidth-1:0]  paddr,
  input  logic [mfr_pkg::PdataWidth-1:0]  pwdata,
  output logic [mfr_pkg::PdataWidth-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  mfr_pkg::cfg_t     cfg;
  mfr_pkg::mem_ctl_t mem_ctl;
  mfr_pkg::result_t  res;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [7:0]        wdata;
  logic [7:0]        rdata;
  logic              accept;
  logic              adv_out;

  logic              s1_valid_q, s1_valid_d;
  mfr_pkg::result_t  s1_q;
  logic              out_valid_q, out_valid_d;
  mfr_pkg::result_t  out_q;
  logic [7:0]        out_byte_q;

  mfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mfr_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (items_i.operation),
    .rx_byte_i    (items_i.rx_byte),
    .read_index_i (items_i.read_index),
    .cfg_i        (cfg),
    .mem_ctl_o    (mem_ctl),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_o      (raddr),
    .result_o     (res)
  );

  mfr_buffer #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_buffer (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign adv_out       = s1_valid_q && (!out_valid_q || results_o.ready);
  assign items_i.ready = !s1_valid_q || adv_out;
  assign accept        = items_i.valid && items_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv_out) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv_out) begin
      out_valid_d = 1'b1;
    end else if (results_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
    if (adv_out) begin
      out_q      <= s1_q;
      out_byte_q <= s1_q.rd_sel ? rdata : 8'd0;
    end
  end

  assign results_o.valid        = out_valid_q;
  assign results_o.event_res    = out_q.ev;
  assign results_o.frame_length = out_q.frame_length;
  assign results_o.read_byte    = out_byte_q;
  assign results_o.frame_open   = out_q.frame_open;

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !results_o.ready) |-> !items_i.ready)
    else $error("input taken while both stages are full and stalled");

  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted word lost before the buffer stage");

  a_close_events : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.ev == mfr_pkg::EV_COMPLETE || out_q.ev == mfr_pkg::EV_OVERFLOW ||
     out_q.ev == mfr_pkg::EV_TO_DROP || out_q.ev == mfr_pkg::EV_TO_DELIVER))
    |-> !out_q.frame_open)
    else $error("frame still open after a closing event");

  a_open_events : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.ev == mfr_pkg::EV_START || out_q.ev == mfr_pkg::EV_RESTART ||
     out_q.ev == mfr_pkg::EV_STORED)) |-> out_q.frame_open)
    else $error("frame not open after an opening or stored event");

endmodule

// ===== design/mfr_cfg.sv =====
// apb configuration registers
module mfr_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mfr_pkg::PaddrWidth-1:0]  paddr,
  input  logic [mfr_pkg::PdataWidth-1:0]  pwdata,
  output logic [mfr_pkg::PdataWidth-1:0]  prdata,
  output logic                            pready,
  output mfr_pkg::cfg_t                   cfg_o
);

  mfr_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        mfr_pkg::REG_SOF_BYTE:      cfg_d.sof_byte      = pwdata[7:0];
        mfr_pkg::REG_EOF_BYTE:      cfg_d.eof_byte      = pwdata[7:0];
        mfr_pkg::REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mfr_pkg::REG_SOF_BYTE:      prdata = {24'd0, cfg_q.sof_byte};
      mfr_pkg::REG_EOF_BYTE:      prdata = {24'd0, cfg_q.eof_byte};
      mfr_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, cfg_q.timeout_ticks};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sof_byte      <= mfr_pkg::SofByteRst;
      cfg_q.eof_byte      <= mfr_pkg::EofByteRst;
      cfg_q.timeout_ticks <= mfr_pkg::TimeoutTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/mfr_buffer.sv =====
// frame byte memory, one write and one registered read port
module mfr_buffer #(
  parameter int unsigned BUFFER_DEPTH = 512,
  parameter int unsigned AW           = 9
) (
  input  logic              clk_i,
  input  mfr_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mfr_ctrl.sv =====
// frame state, marker decoding and buffer access control
module mfr_ctrl #(
  parameter int unsigned BUFFER_DEPTH = 512,
  parameter int unsigned AW           = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    operation_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic [mfr_pkg::IdxWidth-1:0]  read_index_i,
  input  mfr_pkg::cfg_t                 cfg_i,
  output mfr_pkg::mem_ctl_t             mem_ctl_o,
  output logic [AW-1:0]                 waddr_o,
  output logic [7:0]                    wdata_o,
  output logic [AW-1:0]                 raddr_o,
  output mfr_pkg::result_t              result_o
);

  localparam int unsigned CW = ((AW > mfr_pkg::IdxWidth) ? AW : mfr_pkg::IdxWidth) + 1;
  localparam logic [AW-1:0] CntLast   = AW'(BUFFER_DEPTH - 1);
  localparam logic [AW-1:0] CntBrace  = AW'(BUFFER_DEPTH - 2);
  localparam logic [AW-1:0] CntPfx    = AW'(mfr_pkg::PrefixLen);
  localparam logic [AW-1:0] CntPfxEnd = AW'(mfr_pkg::PrefixLen - 1);
  localparam logic [AW-1:0] CntMinLen = AW'(mfr_pkg::MinDeliverLen);

  logic          coll_q, coll_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [15:0]   el_q, el_d;
  logic          pok_q, pok_d;
  logic          match_q, match_d;
  logic [7:0]    last_q, last_d;

  logic          store;
  logic          rd_req;
  logic [7:0]    store_byte;
  logic [15:0]   el_inc;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] cnt_ext;
  logic          pfx_hit;
  mfr_pkg::event_e ev;

  assign el_inc     = (el_q == mfr_pkg::TicksMax) ? el_q : el_q + 16'd1;
  assign idx_ext    = CW'(read_index_i);
  assign store_byte = (operation_i == mfr_pkg::OP_TICK) ? mfr_pkg::BraceClose : rx_byte_i;
  assign pfx_hit    = (store_byte == mfr_pkg::prefix_byte(cnt_q[2:0]));

  always_comb begin
    coll_d  = coll_q;
    cnt_d   = cnt_q;
    el_d    = el_q;
    pok_d   = pok_q;
    match_d = match_q;
    last_d  = last_q;
    store   = 1'b0;
    rd_req  = 1'b0;
    ev      = mfr_pkg::EV_NONE;

    case (operation_i)
      mfr_pkg::OP_BYTE: begin
        if (rx_byte_i == cfg_i.sof_byte) begin
          ev      = coll_q ? mfr_pkg::EV_RESTART : mfr_pkg::EV_START;
          coll_d  = 1'b1;
          cnt_d   = '0;
          el_d    = '0;
          pok_d   = 1'b0;
          match_d = 1'b1;
        end else if (coll_q && rx_byte_i == cfg_i.eof_byte) begin
          coll_d = 1'b0;
          ev     = mfr_pkg::EV_COMPLETE;
        end else if (coll_q) begin
          if (cnt_q < CntLast) begin
            store = 1'b1;
            ev    = mfr_pkg::EV_STORED;
          end else begin
            coll_d = 1'b0;
            ev     = mfr_pkg::EV_OVERFLOW;
          end
        end
      end
      mfr_pkg::OP_TICK: begin
        el_d = el_inc;
        if (coll_q && el_inc > cfg_i.timeout_ticks) begin
          coll_d = 1'b0;
          if (pok_q && cnt_q > CntMinLen) begin
            store = (last_q != mfr_pkg::BraceClose) && (cnt_q < CntBrace);
            ev    = mfr_pkg::EV_TO_DELIVER;
          end else begin
            ev = mfr_pkg::EV_TO_DROP;
          end
        end
      end
      mfr_pkg::OP_READ: begin
        rd_req = accept_i;
      end
      default: ;
    endcase

    if (store) begin
      if (cnt_q < CntPfx) begin
        match_d = match_q && pfx_hit;
      end
      if (cnt_q == CntPfxEnd) begin
        pok_d = match_q && pfx_hit;
      end
      last_d = store_byte;
      cnt_d  = cnt_q + AW'(1);
    end
  end

  assign mem_ctl_o.wr_en = accept_i && store;
  assign mem_ctl_o.rd_en = rd_req;
  assign waddr_o = cnt_q;
  assign wdata_o = store_byte;
  assign raddr_o = idx_ext[AW-1:0];
  assign cnt_ext = CW'(cnt_d);

  assign result_o.ev           = ev;
  assign result_o.frame_length = cnt_ext[mfr_pkg::LenWidth-1:0];
  assign result_o.frame_open   = coll_d;
  assign result_o.rd_sel       = (operation_i == mfr_pkg::OP_READ) &&
                                 (idx_ext < CW'(BUFFER_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q  <= 1'b0;
      cnt_q   <= '0;
      el_q    <= '0;
      pok_q   <= 1'b0;
      match_q <= 1'b0;
      last_q  <= '0;
    end else if (accept_i) begin
      coll_q  <= coll_d;
      cnt_q   <= cnt_d;
      el_q    <= el_d;
      pok_q   <= pok_d;
      match_q <= match_d;
      last_q  <= last_d;
    end
  end

endmodule
